>>> src/bcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg - shared types and helpers for the bounded circular deque
// Sizes, operation codes, controller states, the command/status bundles
// and the modular pointer arithmetic of the ring.
// ----------------------------------------------------------------------------
package bcd_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int PTR_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int MODE_W      = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_REAR  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_EXEC  = 2'd1,
      ST_FETCH = 2'd2,
      ST_LOAD  = 2'd3
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the incoming transaction
      logic execute;   // update store, pointers and count
      logic fetch;     // read front and rear entries
      logic load;      // fill the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // response register can take a new result
   } status_type;

   // clamp a written capacity into 1..STORE_DEPTH
   function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] raw);
      logic [CNT_W-1:0] res;
      res = raw;
      if (raw == '0) begin
         res = CNT_W'(1);
      end else if (raw > CNT_W'(STORE_DEPTH)) begin
         res = CNT_W'(STORE_DEPTH);
      end
      return res;
   endfunction

   // step forward around the ring
   function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(p) + CNT_W'(1);
      return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
   endfunction

   // step backward around the ring
   function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] top;
      top = cap - CNT_W'(1);
      return (p == '0) ? top[PTR_W-1:0] : p - PTR_W'(1);
   endfunction

endpackage

>>> src/bcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_if - channel interfaces of the bounded circular deque
// Request, response and capacity-write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface bcd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [31:0] value;
   modport source (output valid, mode, value, input ready);
   modport sink   (input valid, mode, value, output ready);
endinterface

interface bcd_rsp_if;
   logic               valid;
   logic               ready;
   logic               ok;
   logic signed [31:0] front_value;
   logic signed [31:0] rear_value;
   logic               is_empty;
   logic               is_full;
   modport source (output valid, ok, front_value, rear_value, is_empty, is_full,
                   input ready);
   modport sink   (input valid, ok, front_value, rear_value, is_empty, is_full,
                   output ready);
endinterface

interface bcd_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] capacity;
   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

>>> src/bcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_ctrl - operation sequencer
// Steps each transaction through execute, fetch and load, and holds the
// load until the response register is free.
// ----------------------------------------------------------------------------
module bcd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bcd_pkg::status_type status,
   output bcd_pkg::cmd_type    cmd
);
   import bcd_pkg::*;

   state_type state_ff;
   state_type state_in;

   // advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC:  state_in = ST_FETCH;
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC:  cmd.execute = 1'b1;
         ST_FETCH: cmd.fetch   = 1'b1;
         ST_LOAD:  cmd.load    = status.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> src/bcd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_datapath - ring store, pointers, count and response register
// Carries out the operation picked by the controller and builds the result.
// ----------------------------------------------------------------------------
module bcd_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  bcd_pkg::cmd_type           cmd,
   output bcd_pkg::status_type        status,
   input  logic [bcd_pkg::MODE_W-1:0] req_mode,
   input  logic [bcd_pkg::DATA_W-1:0] req_value,
   input  logic                       csr_write,
   input  logic [bcd_pkg::CNT_W-1:0]  csr_capacity,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_ok,
   output logic [bcd_pkg::DATA_W-1:0] rsp_front_value,
   output logic [bcd_pkg::DATA_W-1:0] rsp_rear_value,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full
);
   import bcd_pkg::*;

   logic [DATA_W-1:0] store_mem [STORE_DEPTH];

   mode_type          mode_ff;
   logic [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]  cap_ff,   cap_in;
   logic [PTR_W-1:0]  front_ff, front_in;
   logic [PTR_W-1:0]  rear_ff,  rear_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ok_ff,    ok_in;
   logic [DATA_W-1:0] rd_front_ff;
   logic [DATA_W-1:0] rd_rear_ff;
   logic              out_valid_ff, out_valid_in;
   logic              out_ok_ff;
   logic [DATA_W-1:0] out_front_ff, out_rear_ff;
   logic              out_empty_ff, out_full_ff;

   logic              full;
   logic              is_push;
   logic              do_write;
   logic [PTR_W-1:0]  wr_addr;

   // capture the transaction payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_value;
      end
   end

   // operation decode
   always_comb begin
      full     = (count_ff >= cap_ff);
      is_push  = (mode_ff == MODE_PUSH_FRONT) || (mode_ff == MODE_PUSH_REAR);
      ok_in    = is_push ? !full : (count_ff != '0);
      do_write = cmd.execute && is_push && ok_in;
      wr_addr  = (mode_ff == MODE_PUSH_FRONT) ? front_ff : rear_ff;
   end

   // next pointers, count and capacity
   always_comb begin
      cap_in   = cap_ff;
      front_in = front_ff;
      rear_in  = rear_ff;
      count_in = count_ff;
      if (csr_write) begin
         cap_in   = eff_cap(csr_capacity);
         front_in = '0;
         rear_in  = ring_inc('0, cap_in);
         count_in = '0;
      end else if (cmd.execute && ok_in) begin
         case (mode_ff)
            MODE_PUSH_FRONT: begin
               front_in = ring_dec(front_ff, cap_ff);
               count_in = count_ff + CNT_W'(1);
            end
            MODE_PUSH_REAR: begin
               rear_in  = ring_inc(rear_ff, cap_ff);
               count_in = count_ff + CNT_W'(1);
            end
            MODE_POP_FRONT: begin
               front_in = ring_inc(front_ff, cap_ff);
               count_in = count_ff - CNT_W'(1);
            end
            default: begin
               rear_in  = ring_dec(rear_ff, cap_ff);
               count_in = count_ff - CNT_W'(1);
            end
         endcase
      end
   end

   // hold ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CNT_W'(STORE_DEPTH);
         front_ff <= '0;
         rear_ff  <= ring_inc('0, CNT_W'(STORE_DEPTH));
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   // keep the outcome of the operation
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         ok_ff <= ok_in;
      end
   end

   // store write and registered reads of the end entries
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_mem[wr_addr] <= value_ff;
      end
      if (cmd.fetch) begin
         rd_front_ff <= store_mem[ring_inc(front_ff, cap_ff)];
         rd_rear_ff  <= store_mem[ring_dec(rear_ff, cap_ff)];
      end
   end

   // response valid: set on load, drop when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_ok_ff    <= ok_ff;
         out_front_ff <= (count_ff == '0) ? '1 : rd_front_ff;
         out_rear_ff  <= (count_ff == '0) ? '1 : rd_rear_ff;
         out_empty_ff <= (count_ff == '0);
         out_full_ff  <= full;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_ok          = out_ok_ff;
   assign rsp_front_value = out_front_ff;
   assign rsp_rear_value  = out_rear_ff;
   assign rsp_is_empty    = out_empty_ff;
   assign rsp_is_full     = out_full_ff;

endmodule

>>> src/bounded_circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_circular_deque - ring-buffer double-ended queue
// Push/pop at either end with a programmable capacity; one result per
// operation with the outcome, both end values and the empty/full flags.
//
//   channel    dir  payload                                        handshake
//   req_chan   in   mode, value                                    valid/ready
//   rsp_chan   out  ok, front_value, rear_value, is_empty, is_full valid/ready
//   csr_chan   in   capacity                                       valid/ready
//
// Each operation steps through accept, execute, fetch of both end entries
// from the registered-read store, and load of the response register.
// Reset empties the deque and sets the capacity to 16; the store keeps no
// reset value. A capacity write empties the deque and is always taken.
// A stalled response holds only the load step; a new request is taken
// while the previous result still waits in the response register.
// ----------------------------------------------------------------------------
module bounded_circular_deque (
   input logic      clock,
   input logic      reset,
   bcd_req_if.sink  req_chan,
   bcd_rsp_if.source rsp_chan,
   bcd_csr_if.sink  csr_chan
);
   import bcd_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   bcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_chan.mode),
      .req_value       (req_chan.value),
      .csr_write       (csr_chan.valid),
      .csr_capacity    (csr_chan.capacity),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_ok          (rsp_chan.ok),
      .rsp_front_value (rsp_chan.front_value),
      .rsp_rear_value  (rsp_chan.rear_value),
      .rsp_is_empty    (rsp_chan.is_empty),
      .rsp_is_full     (rsp_chan.is_full)
   );

`ifndef SYNTHESIS
   // an accepted request goes straight to execution
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> cmd.execute)
      else $error("accepted request did not execute");

   // the store is read right after execution
   a_exec_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (cmd.fetch && !req_ready))
      else $error("execution not followed by fetch");

   // a full deque is never empty, capacity is at least one
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_full) |-> !rsp_chan.is_empty)
      else $error("response both full and empty");
`endif

endmodule
